// File: hw/rtl/hce_pkg.sv
package hce_pkg;

  // Datapath widths
  localparam int ACC_W     = 64;  // running binomial value and products
  localparam int FAC_W     = 18;  // multiplier operand: a factor or one group binomial
  localparam int GRP_W     = 5;   // group size, items taken, divisor
  localparam int DRAW_W    = 6;   // draw size and binomial totals
  localparam int WAYS_W    = 53;
  localparam int TOTAL_W   = 57;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = ACC_W / 2;  // radix-4: two quotient bits per cycle

  // Register map, in units of 32-bit words
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_FIRST  = 2'd0;
  localparam reg_idx_t REG_SECOND = 2'd1;
  localparam reg_idx_t REG_THIRD  = 2'd2;
  localparam reg_idx_t REG_DRAW   = 2'd3;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_t;

  typedef struct packed {
    logic              start;
    md_op_t            op;
    logic [ACC_W-1:0]  a;
    logic [FAC_W-1:0]  b;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [ACC_W-1:0]  result;
  } md_rsp_t;

  typedef struct packed {
    logic [GRP_W-1:0]  first;
    logic [GRP_W-1:0]  second;
    logic [GRP_W-1:0]  third;
    logic [DRAW_W-1:0] draw;
  } grp_cfg_t;

endpackage

// File: hw/rtl/hypergeometric_count_engine.sv
// Each multiply-then-divide step of a binomial is a shift-add multiply over the factor bits
// and then a radix-4 divide in the shared unit; one transfer takes up to 60 such steps plus
// two product multiplies.
// Throughput: one item at a time; busy stays high until the result strobe, and the
// receiver cannot stall. Reset (rst_n low, synchronous) clears all group/draw registers to 0.
module hypergeometric_count_engine import hce_pkg::*; #(
  parameter int MAX_GROUP = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic [GRP_W-1:0]    in_first_taken,
  input  logic [GRP_W-1:0]    in_second_taken,
  // result channel, one-cycle strobe
  output logic                out_valid,
  output logic [WAYS_W-1:0]   out_ways_count,
  output logic [TOTAL_W-1:0]  out_total_ways,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam logic [GRP_W-1:0] SAT_LIM = GRP_W'(MAX_GROUP);

  logic [GRP_W-1:0]   first_r;
  logic [GRP_W-1:0]   second_r;
  logic [GRP_W-1:0]   third_r;
  logic [DRAW_W-1:0]  draw_r;

  reg_idx_t           reg_idx;
  logic               cfg_wr;
  logic               go;
  grp_cfg_t           grp_cfg;
  md_req_t            md_req;
  md_rsp_t            md_rsp;

  // Word-aligned register select; the low address bits do not matter
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= '0;
      second_r <= '0;
      third_r  <= '0;
      draw_r   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FIRST:  first_r  <= pwdata[GRP_W-1:0];
        REG_SECOND: second_r <= pwdata[GRP_W-1:0];
        REG_THIRD:  third_r  <= pwdata[GRP_W-1:0];
        REG_DRAW:   draw_r   <= pwdata[DRAW_W-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the raw register value, before saturation
  always_comb begin
    unique case (reg_idx)
      REG_FIRST:  prdata = DATA_W'(first_r);
      REG_SECOND: prdata = DATA_W'(second_r);
      REG_THIRD:  prdata = DATA_W'(third_r);
      REG_DRAW:   prdata = DATA_W'(draw_r);
      default:    prdata = '0;
    endcase
  end

  // Clamp each group size to MAX_GROUP before it reaches the datapath
  assign grp_cfg.first  = (first_r  > SAT_LIM) ? SAT_LIM : first_r;
  assign grp_cfg.second = (second_r > SAT_LIM) ? SAT_LIM : second_r;
  assign grp_cfg.third  = (third_r  > SAT_LIM) ? SAT_LIM : third_r;
  assign grp_cfg.draw   = draw_r;

  // A command transfer happens only while the sequencer is idle
  assign go = start && !busy;

  hce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .x_in      (in_first_taken),
    .y_in      (in_second_taken),
    .cfg       (grp_cfg),
    .busy      (busy),
    .out_valid (out_valid),
    .ways      (out_ways_count),
    .total     (out_total_ways),
    .md_req    (md_req),
    .md_rsp    (md_rsp)
  );

  // Single multiply/divide unit shared by every binomial step and the final products
  hce_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

endmodule

// File: hw/rtl/hce_muldiv.sv
// Shared shift-add multiplier and radix-4 restoring divider.
module hce_muldiv import hce_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } state_t;

  state_t              state_r;
  logic                done_r;
  logic [ACC_W-1:0]    work_r;
  logic [ACC_W-1:0]    aux_r;
  logic [FAC_W-1:0]    b_r;
  logic [GRP_W-1:0]    rem_r;
  logic [CNT_W-1:0]    cnt_r;

  logic [ACC_W-1:0]    addend;
  logic [ACC_W-1:0]    mul_sum;
  logic [GRP_W+1:0]    trial;
  logic [GRP_W+1:0]    d1;
  logic [GRP_W+1:0]    d2;
  logic [GRP_W+1:0]    d3;
  logic [GRP_W+1:0]    sub;
  logic [GRP_W+1:0]    rem_wide;
  logic [1:0]          qdig;

  assign addend  = b_r[0] ? aux_r : '0;
  assign mul_sum = work_r + addend;

  // One radix-4 digit: compare partial remainder against d, 2d, 3d
  always_comb begin
    d1    = {2'b00, b_r[GRP_W-1:0]};
    d2    = {1'b0, b_r[GRP_W-1:0], 1'b0};
    d3    = d1 + d2;
    trial = {rem_r, work_r[ACC_W-1 -: 2]};
    if (trial >= d3) begin
      qdig = 2'd3;
      sub  = d3;
    end else if (trial >= d2) begin
      qdig = 2'd2;
      sub  = d2;
    end else if (trial >= d1) begin
      qdig = 2'd1;
      sub  = d1;
    end else begin
      qdig = 2'd0;
      sub  = '0;
    end
    rem_wide = trial - sub;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (req.start) begin
            aux_r <= req.a;
            b_r   <= req.b;
            rem_r <= '0;
            cnt_r <= '0;
            if (req.op == MD_MUL) begin
              work_r  <= '0;
              state_r <= ST_MUL;
            end else begin
              work_r  <= req.a;
              state_r <= ST_DIV;
            end
          end
        end
        ST_MUL: begin
          if (b_r == '0) begin
            done_r  <= 1'b1;
            state_r <= ST_IDLE;
          end else begin
            work_r <= mul_sum;
            aux_r  <= {aux_r[ACC_W-2:0], 1'b0};
            b_r    <= {1'b0, b_r[FAC_W-1:1]};
          end
        end
        ST_DIV: begin
          work_r <= {work_r[ACC_W-3:0], qdig};
          rem_r  <= rem_wide[GRP_W-1:0];
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            done_r  <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = work_r;

endmodule

// File: hw/rtl/hce_ctrl.sv
// Sequencer: up to four binomials in the shared unit, and the ways product.
module hce_ctrl import hce_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [GRP_W-1:0]    x_in,
  input  logic [GRP_W-1:0]    y_in,
  input  grp_cfg_t            cfg,
  output logic                busy,
  output logic                out_valid,
  output logic [WAYS_W-1:0]   ways,
  output logic [TOTAL_W-1:0]  total,
  output md_req_t             md_req,
  input  md_rsp_t             md_rsp
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_MUL_WAIT,
    S_DIV,
    S_DIV_WAIT,
    S_END,
    S_PROD,
    S_PROD_WAIT
  } state_t;

  typedef enum logic [1:0] {
    JOB_TOTAL,
    JOB_FIRST,
    JOB_SECOND,
    JOB_THIRD
  } job_t;

  state_t              state_r;
  job_t                job_r;
  logic                valid_r;
  logic [GRP_W-1:0]    x_r;
  logic [GRP_W-1:0]    y_r;
  logic [DRAW_W-1:0]   tot_r;
  logic [GRP_W-1:0]    k_r;
  logic [GRP_W-1:0]    i_r;
  logic [ACC_W-1:0]    acc_r;
  logic [ACC_W-1:0]    prod_r;
  logic [TOTAL_W-1:0]  total_r;

  logic [DRAW_W:0]     grp_sum;
  logic [DRAW_W-1:0]   take_sum;
  logic [DRAW_W-1:0]   rest;
  logic                fits;
  logic [DRAW_W-1:0]   setup_tot;
  logic [DRAW_W-1:0]   setup_pick;
  logic [DRAW_W-1:0]   comp;
  logic [DRAW_W-1:0]   short_pick;
  logic [GRP_W-1:0]    i_inc;
  logic [DRAW_W-1:0]   factor;

  assign grp_sum  = {2'b00, cfg.first} + {2'b00, cfg.second} + {2'b00, cfg.third};
  assign take_sum = {1'b0, x_r} + {1'b0, y_r};
  assign rest     = cfg.draw - take_sum;
  assign fits     = (take_sum <= cfg.draw) && (rest <= {1'b0, cfg.third});
  assign i_inc    = i_r + 1'b1;
  assign factor   = tot_r - {1'b0, i_r};

  always_comb begin
    unique case (job_r)
      JOB_TOTAL: begin
        setup_tot  = grp_sum[DRAW_W-1:0];
        setup_pick = cfg.draw;
      end
      JOB_FIRST: begin
        setup_tot  = {1'b0, cfg.first};
        setup_pick = {1'b0, x_r};
      end
      JOB_SECOND: begin
        setup_tot  = {1'b0, cfg.second};
        setup_pick = {1'b0, y_r};
      end
      default: begin
        setup_tot  = {1'b0, cfg.third};
        setup_pick = rest;
      end
    endcase
    comp       = setup_tot - setup_pick;
    short_pick = (setup_pick > comp) ? comp : setup_pick;
  end

  // Request to the shared unit, decoded from state
  always_comb begin
    md_req.start = (state_r == S_MUL) || (state_r == S_DIV) || (state_r == S_PROD);
    md_req.op    = (state_r == S_DIV) ? MD_DIV : MD_MUL;
    md_req.a     = (state_r == S_PROD) ? prod_r : acc_r;
    unique case (state_r)
      S_DIV:   md_req.b = FAC_W'(i_inc);
      S_PROD:  md_req.b = acc_r[FAC_W-1:0];
      default: md_req.b = FAC_W'(factor);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      job_r   <= JOB_TOTAL;
    end else begin
      valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (go) begin
            x_r     <= x_in;
            y_r     <= y_in;
            job_r   <= JOB_TOTAL;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          tot_r <= setup_tot;
          i_r   <= '0;
          k_r   <= short_pick[GRP_W-1:0];
          if (setup_pick > setup_tot) begin
            acc_r   <= '0;
            state_r <= S_END;
          end else begin
            acc_r   <= ACC_W'(1);
            state_r <= (short_pick == '0) ? S_END : S_MUL;
          end
        end
        S_MUL:  state_r <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (md_rsp.done) begin
            acc_r   <= md_rsp.result;
            state_r <= S_DIV;
          end
        end
        S_DIV:  state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (md_rsp.done) begin
            acc_r   <= md_rsp.result;
            i_r     <= i_inc;
            state_r <= (i_inc == k_r) ? S_END : S_MUL;
          end
        end
        S_END: begin
          unique case (job_r)
            JOB_TOTAL: begin
              total_r <= acc_r[TOTAL_W-1:0];
              if (fits) begin
                job_r   <= JOB_FIRST;
                state_r <= S_SETUP;
              end else begin
                prod_r  <= '0;
                valid_r <= 1'b1;
                state_r <= S_IDLE;
              end
            end
            JOB_FIRST: begin
              prod_r  <= acc_r;
              job_r   <= JOB_SECOND;
              state_r <= S_SETUP;
            end
            default: state_r <= S_PROD;
          endcase
        end
        S_PROD: state_r <= S_PROD_WAIT;
        S_PROD_WAIT: begin
          if (md_rsp.done) begin
            prod_r <= md_rsp.result;
            if (job_r == JOB_SECOND) begin
              job_r   <= JOB_THIRD;
              state_r <= S_SETUP;
            end else begin
              valid_r <= 1'b1;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;
  assign ways      = prod_r[WAYS_W-1:0];
  assign total     = total_r;

endmodule
